// File: rtl/core/integer_field_formatter_unit_defines.svh
// ----------------------------------------------------------------------------
// Integer field formatter assertion macros
// Shared concurrent assertion macros for the formatter RTL. The checking forms
// are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising edge of clk_i while out of reset.
`define IFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checks that a condition never holds.
`define IFF_ASSERT_NEVER(lbl, cond, msg) `IFF_ASSERT(lbl, !(cond), msg)
`else
`define IFF_ASSERT(lbl, prop, msg)
`define IFF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/core/iff_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Types, constants and the digit-to-ASCII function of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package iff_pkg;

  localparam int VALUE_W    = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int SRC_W      = 40;

  // Digit counts before leading-zero removal.
  localparam int ND_DEC = BCD_DIGITS;
  localparam int ND_OCT = 11;
  localparam int ND_BIN = 32;
  localparam int ND_HEX = 8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_OCT  = 3'd2,
    KIND_BIN  = 3'd3,
    KIND_HEX  = 3'd4,
    KIND_CHAR = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    DSZ_1 = 2'd0,
    DSZ_3 = 2'd1,
    DSZ_4 = 2'd2
  } dsz_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_EMIT
  } state_e;

  // Lowercase hexadecimal digit set.
  function automatic logic [7:0] digit_char(input logic [3:0] dig);
    logic [7:0] ch;
    if (dig < 4'd10) begin
      ch = 8'h30 + {4'd0, dig};
    end else begin
      ch = 8'h57 + {4'd0, dig};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/integer_field_formatter_unit.sv
// ----------------------------------------------------------------------------
// Integer field formatter
// Formats one 32-bit value as a padded field of ASCII characters, one
// character word per output strobe.
// ----------------------------------------------------------------------------
// Usage: drive kind_i, value_i, width_i and min_digits_i and raise start. The
// word is taken at a rising edge where start is high and busy is low. The
// field then leaves one character per cycle on character_o, each marked by a
// one-cycle valid_o pulse; last_o is high on the final character. The
// receiver cannot stall, so every character appears exactly once.
// Decimal kinds first run a bit-serial binary-to-BCD conversion and then hand
// the digits over. The numeric kinds then strip leading zero digits one digit
// per cycle (up to 9 for decimal, 31 for binary), stop at the first nonzero
// digit, pass a setup state and emit max(width, min_digits, sign + digits)
// characters, one per cycle. A word keeps the block busy until its last
// character is issued, and no new word is taken before then. A single
// character word returns its one character in the cycle after acceptance;
// the unused kinds are accepted and produce nothing. Reset returns the
// block to idle and drops any field in progress.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_field_formatter_unit_defines.svh"

module integer_field_formatter_unit #(
  parameter int MAX_FIELD = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] value_i,
  input  wire logic [5:0]  width_i,
  input  wire logic [5:0]  min_digits_i,
  output logic             valid_o,
  output logic [7:0]       character_o,
  output logic             last_o
);

  localparam int CW    = $clog2(MAX_FIELD + 1);
  localparam int SRC_W = iff_pkg::SRC_W;

  iff_pkg::state_e state_q, state_d;
  iff_pkg::dsz_e   dsz_q, dsz_d;

  // Digits are held left-aligned; the top digit is always the next one out.
  logic [SRC_W-1:0] src_q, src_d, src_shift;
  logic [CW-1:0]    nd_q, nd_d;
  logic [CW-1:0]    width_q, width_d;
  logic [CW-1:0]    mind_q, mind_d;
  logic [CW-1:0]    dlen_q, dlen_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic             neg_q, neg_d;
  logic             valid_q, valid_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;

  logic                         accept;
  logic                         neg_in;
  logic [31:0]                  mag;
  logic                         bcd_start, bcd_done;
  logic [iff_pkg::BCD_W-1:0]    bcd;
  logic [3:0]                   top_dig;
  logic [CW-1:0]                width_cl, mind_cl, cnt, dlen, total;

  assign accept = start && !busy;
  assign neg_in = (kind_i == iff_pkg::KIND_SDEC) && value_i[31];
  assign mag    = neg_in ? (~value_i + 32'd1) : value_i;

  assign bcd_start = accept &&
                     (kind_i == iff_pkg::KIND_SDEC || kind_i == iff_pkg::KIND_UDEC);

  iff_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(bcd_start),
    .bin_i  (mag),
    .done_o (bcd_done),
    .bcd_o  (bcd)
  );

  // Paddings are limited to the largest field the counters can describe.
  assign width_cl = (CW'(width_i) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(width_i);
  assign mind_cl  = (CW'(min_digits_i) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                         : CW'(min_digits_i);

  always_comb begin
    case (dsz_q)
      iff_pkg::DSZ_1: begin
        top_dig   = {3'd0, src_q[SRC_W-1]};
        src_shift = {src_q[SRC_W-2:0], 1'b0};
      end
      iff_pkg::DSZ_3: begin
        top_dig   = {1'b0, src_q[SRC_W-1 -: 3]};
        src_shift = {src_q[SRC_W-4:0], 3'd0};
      end
      default: begin
        top_dig   = src_q[SRC_W-1 -: 4];
        src_shift = {src_q[SRC_W-5:0], 4'd0};
      end
    endcase
  end

  // The minus sign counts as a digit toward the minimum digit count.
  assign cnt   = nd_q + CW'(neg_q);
  assign dlen  = (mind_q > cnt) ? mind_q : cnt;
  assign total = (width_q > dlen) ? width_q : dlen;

  always_comb begin
    state_d = state_q;
    dsz_d   = dsz_q;
    src_d   = src_q;
    nd_d    = nd_q;
    width_d = width_q;
    mind_d  = mind_q;
    dlen_d  = dlen_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    valid_d = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    case (state_q)
      iff_pkg::ST_IDLE: begin
        if (accept) begin
          neg_d   = neg_in;
          width_d = width_cl;
          mind_d  = mind_cl;
          case (kind_i)
            iff_pkg::KIND_SDEC, iff_pkg::KIND_UDEC: begin
              state_d = iff_pkg::ST_CONV;
            end
            iff_pkg::KIND_OCT: begin
              src_d   = {1'b0, value_i, 7'd0};
              nd_d    = CW'(iff_pkg::ND_OCT);
              dsz_d   = iff_pkg::DSZ_3;
              state_d = iff_pkg::ST_NORM;
            end
            iff_pkg::KIND_BIN: begin
              src_d   = {value_i, 8'd0};
              nd_d    = CW'(iff_pkg::ND_BIN);
              dsz_d   = iff_pkg::DSZ_1;
              state_d = iff_pkg::ST_NORM;
            end
            iff_pkg::KIND_HEX: begin
              src_d   = {value_i, 8'd0};
              nd_d    = CW'(iff_pkg::ND_HEX);
              dsz_d   = iff_pkg::DSZ_4;
              state_d = iff_pkg::ST_NORM;
            end
            iff_pkg::KIND_CHAR: begin
              valid_d = 1'b1;
              char_d  = value_i[7:0];
              last_d  = 1'b1;
            end
            default: begin
              // Unused kinds produce no characters.
            end
          endcase
        end
      end
      iff_pkg::ST_CONV: begin
        if (bcd_done) begin
          src_d   = bcd;
          nd_d    = CW'(iff_pkg::ND_DEC);
          dsz_d   = iff_pkg::DSZ_4;
          state_d = iff_pkg::ST_NORM;
        end
      end
      iff_pkg::ST_NORM: begin
        // Drop leading zero digits, keeping at least one digit.
        if (top_dig == 4'd0 && nd_q > CW'(1)) begin
          src_d = src_shift;
          nd_d  = nd_q - CW'(1);
        end else begin
          state_d = iff_pkg::ST_SETUP;
        end
      end
      iff_pkg::ST_SETUP: begin
        dlen_d  = dlen;
        rem_d   = total;
        state_d = iff_pkg::ST_EMIT;
      end
      iff_pkg::ST_EMIT: begin
        valid_d = 1'b1;
        last_d  = (rem_q == CW'(1));
        if (rem_q > dlen_q) begin
          char_d = iff_pkg::CH_SPACE;
        end else if (neg_q && rem_q == dlen_q) begin
          char_d = iff_pkg::CH_MINUS;
        end else if (rem_q > nd_q) begin
          char_d = iff_pkg::CH_ZERO;
        end else begin
          char_d = iff_pkg::digit_char(top_dig);
          src_d  = src_shift;
        end
        rem_d = rem_q - CW'(1);
        if (rem_q == CW'(1)) begin
          state_d = iff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iff_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iff_pkg::ST_IDLE;
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsz_q   <= dsz_d;
    src_q   <= src_d;
    nd_q    <= nd_d;
    width_q <= width_d;
    mind_q  <= mind_d;
    dlen_q  <= dlen_d;
    neg_q   <= neg_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign busy        = (state_q != iff_pkg::ST_IDLE);
  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // A character that is not the final one always belongs to a field still in
  // progress, so the block must still report busy.
  `IFF_ASSERT(a_mid_field_busy, valid_o && !last_o |-> busy, "mid-field char while idle")
  // An accepted single-character word returns exactly that character next cycle.
  `IFF_ASSERT(a_char_kind, start && !busy && kind_i == iff_pkg::KIND_CHAR |=> valid_o && last_o && character_o == $past(value_i[7:0]), "single character word mismatch")
  // Unused kinds leave the block idle and silent.
  `IFF_ASSERT(a_unused_kind, start && !busy && kind_i > iff_pkg::KIND_CHAR |=> !valid_o && !busy, "unused kind produced output")
  // The character counter never runs out while the field is being emitted.
  `IFF_ASSERT_NEVER(a_rem_underflow, state_q == iff_pkg::ST_EMIT && rem_q == '0, "field counter underflow")

endmodule

`default_nettype wire

// File: rtl/core/iff_bcd.sv
// ----------------------------------------------------------------------------
// Integer field formatter BCD converter
// Bit-serial shift-and-add-3 conversion of a 32-bit magnitude to ten BCD
// digits, one input bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iff_bcd (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [iff_pkg::VALUE_W-1:0]  bin_i,
  output logic                              done_o,
  output logic [iff_pkg::BCD_W-1:0]         bcd_o
);

  localparam int CNT_W = $clog2(iff_pkg::VALUE_W);

  logic [iff_pkg::VALUE_W-1:0] bin_q, bin_d;
  logic [iff_pkg::BCD_W-1:0]   bcd_q, bcd_d, adj;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        run_q, run_d;
  logic                        done_q, done_d;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < iff_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[iff_pkg::BCD_W-2:0], bin_q[iff_pkg::VALUE_W-1]};
      bin_d = {bin_q[iff_pkg::VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(iff_pkg::VALUE_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

// File: tb/integer_field_formatter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Drives format words through the start/busy handshake and checks every
// emitted character against typed text or the behavioral format_field. A short
// table of directed words (extremes, all kinds, padding corners) runs first,
// then several hundred random words with random idle gaps on the sender side.
// ----------------------------------------------------------------------------

module integer_field_formatter_unit_tb;

  // Kinds 6 and 7 are not defined by the block; it takes the word and emits
  // nothing for it.
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  localparam int    NUM_DIRECTED  = 26;
  localparam int    NUM_RANDOM    = 280;
  localparam int    SETTLE_CYCLES = 160;
  localparam int    CYCLE_LIMIT   = 400000;
  localparam string DIGIT_SET     = "0123456789abcdef";

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [5:0]  width;
    logic [5:0]  min_digits;
  } format_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  kind_i;
  logic [31:0] value_i;
  logic [5:0]  width_i;
  logic [5:0]  min_digits_i;
  logic        valid_o;
  logic [7:0]  character_o;
  logic        last_o;

  // Characters still owed by the block, oldest first.
  field_char_t  pending_chars_q [$];
  // Text typed into the directed table for the word being offered; empty
  // means the word is checked against format_field instead.
  string        golden_text;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           no_gap_left    = 0;

  format_word_t dir_words [NUM_DIRECTED];
  string        dir_text  [NUM_DIRECTED];

  always #5 clk_i = ~clk_i;

  integer_field_formatter_unit #(
    .MAX_FIELD(63)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .width_i     (width_i),
    .min_digits_i(min_digits_i),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // Appends the characters one format word must produce to pending_chars_q.
  // The field is spaces, then the sign, then zero padding, then the digits
  // most significant first. The minus sign counts toward min_digits. With
  // 6-bit width and min_digits the MAX_FIELD clamp of 63 never bites.
  function automatic void format_field(input logic [2:0]  kind,
                                       input logic [31:0] value,
                                       input logic [5:0]  width,
                                       input logic [5:0]  min_digits);
    logic [7:0]  digits [32];
    logic [7:0]  line [64];
    logic [31:0] magnitude;
    int          ndig;
    int          step_bits;
    int          sign_digits;
    int          pad_to;
    int          field_len;
    int          n;
    bit          negative;
    ndig      = 0;
    n         = 0;
    negative  = 1'b0;
    magnitude = value;
    // A single character ignores both paddings.
    if (kind == iff_pkg::KIND_CHAR) begin
      pending_chars_q.push_back('{ch: value[7:0], last: 1'b1});
      return;
    end
    if (kind > iff_pkg::KIND_CHAR) begin
      return;
    end
    // The most negative value negates to itself, which still reads correctly
    // as an unsigned magnitude of 2147483648.
    if (kind == iff_pkg::KIND_SDEC && value[31]) begin
      negative  = 1'b1;
      magnitude = 32'd0 - value;
    end
    if (kind == iff_pkg::KIND_SDEC || kind == iff_pkg::KIND_UDEC) begin
      do begin
        digits[ndig] = iff_pkg::CH_ZERO + 8'(magnitude % 32'd10);
        magnitude    = magnitude / 32'd10;
        ndig++;
      end while (magnitude != 32'd0);
    end else begin
      // Octal's top digit falls out of the shift as bits 31..30 alone.
      step_bits = (kind == iff_pkg::KIND_OCT) ? 3 : (kind == iff_pkg::KIND_BIN) ? 1 : 4;
      do begin
        digits[ndig] = DIGIT_SET[int'(magnitude & ((32'd1 << step_bits) - 32'd1))];
        magnitude    = magnitude >> step_bits;
        ndig++;
      end while (magnitude != 32'd0);
    end
    sign_digits = ndig + int'(negative);
    pad_to      = (int'(min_digits) > sign_digits) ? int'(min_digits) : sign_digits;
    field_len   = (int'(width) > pad_to) ? int'(width) : pad_to;
    for (int i = 0; i < field_len - pad_to; i++) begin
      line[n] = iff_pkg::CH_SPACE;
      n++;
    end
    if (negative) begin
      line[n] = iff_pkg::CH_MINUS;
      n++;
    end
    for (int i = 0; i < pad_to - sign_digits; i++) begin
      line[n] = iff_pkg::CH_ZERO;
      n++;
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      line[n] = digits[i];
      n++;
    end
    for (int i = 0; i < n; i++) begin
      pending_chars_q.push_back('{ch: line[i], last: (i == n - 1)});
    end
  endfunction

  // Offers one word and returns at the edge that takes it. The next word may
  // be driven in that same step, which keeps start high across back-to-back
  // words. Otherwise start drops for a random gap; now and then a stretch of
  // words goes out with no gaps at all.
  task automatic send_word(input logic [2:0]  kind,
                           input logic [31:0] value,
                           input logic [5:0]  width,
                           input logic [5:0]  min_digits,
                           input string       text);
    int gap;
    start        <= 1'b1;
    kind_i       <= kind;
    value_i      <= value;
    width_i      <= width;
    min_digits_i <= min_digits;
    golden_text  <= text;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (no_gap_left > 0) begin
      no_gap_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 29) == 0) begin
        no_gap_left = $urandom_range(16, 32);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every owed character has come out. The first
  // edge lets the monitor record the word taken in the current step.
  task automatic wait_fields_done();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_chars_q.size() != 0);
  endtask

  // Output checker and word monitor. Both read the values present just before
  // the edge, so the order against the driver within a step does not matter.
  // Outputs are checked before the word taken at this edge is recorded.
  always @(posedge clk_i) begin : check_outputs
    field_char_t want;
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        if (pending_chars_q.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, character_o, last_o);
          mismatch_count++;
        end else begin
          want = pending_chars_q.pop_front();
          if (character_o !== want.ch) begin
            $display("%0t: character mismatch: expected %h, actual %h",
                     $time, want.ch, character_o);
            mismatch_count++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, last_o);
            mismatch_count++;
          end
        end
      end else if (valid_o !== 1'b0) begin
        $display("%0t: valid_o unknown: expected 0 or 1, actual %b", $time, valid_o);
        mismatch_count++;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (golden_text.len() != 0) begin
          for (int i = 0; i < golden_text.len(); i++) begin
            pending_chars_q.push_back('{ch: golden_text[i],
                                        last: (i == golden_text.len() - 1)});
          end
        end else begin
          format_field(kind_i, value_i, width_i, min_digits_i);
        end
      end
    end
  end

  // Guard against a hung handshake or a field that never completes.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters outstanding",
               $time, pending_chars_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0]  kind;
    logic [31:0] value;
    logic [5:0]  width;
    logic [5:0]  min_digits;
    int          taken;
    bit          paused;

    // Directed words. Text is filled in only where the field is obvious;
    // the remaining rows go through format_field.
    dir_words = '{
      '{iff_pkg::KIND_SDEC, 32'd0,          6'd0,  6'd0},   // zero prints as one digit
      '{iff_pkg::KIND_SDEC, 32'h8000_0000,  6'd0,  6'd0},   // most negative value
      '{iff_pkg::KIND_SDEC, 32'hFFFF_FFFF,  6'd0,  6'd0},
      '{iff_pkg::KIND_SDEC, 32'h7FFF_FFFF,  6'd0,  6'd0},
      '{iff_pkg::KIND_UDEC, 32'hFFFF_FFFF,  6'd0,  6'd0},
      '{iff_pkg::KIND_UDEC, 32'h8000_0000,  6'd0,  6'd0},
      '{iff_pkg::KIND_OCT,  32'hFFFF_FFFF,  6'd0,  6'd0},   // top octal digit is 3
      '{iff_pkg::KIND_OCT,  32'd0,          6'd0,  6'd0},
      '{iff_pkg::KIND_BIN,  32'hFFFF_FFFF,  6'd0,  6'd0},
      '{iff_pkg::KIND_BIN,  32'd1,          6'd0,  6'd0},
      '{iff_pkg::KIND_HEX,  32'hDEAD_BEEF,  6'd0,  6'd0},
      '{iff_pkg::KIND_HEX,  32'hFFFF_FFFF,  6'd10, 6'd0},
      '{iff_pkg::KIND_CHAR, 32'h1234_5641,  6'd63, 6'd63},  // paddings ignored
      '{iff_pkg::KIND_SDEC, 32'hFFFF_FFFB,  6'd6,  6'd3},   // sign counts as a digit
      '{iff_pkg::KIND_UDEC, 32'd42,         6'd0,  6'd5},
      '{iff_pkg::KIND_UDEC, 32'd7,          6'd63, 6'd0},   // widest space padding
      '{iff_pkg::KIND_SDEC, 32'h8000_0000,  6'd0,  6'd63},  // widest zero padding
      '{iff_pkg::KIND_HEX,  32'd0,          6'd63, 6'd63},
      '{iff_pkg::KIND_CHAR, 32'd0,          6'd0,  6'd0},
      '{iff_pkg::KIND_CHAR, 32'hFFFF_FFFF,  6'd1,  6'd1},
      '{iff_pkg::KIND_UDEC, 32'd2000000000, 6'd12, 6'd11},
      '{iff_pkg::KIND_UDEC, 32'd1000000000, 6'd3,  6'd2},   // paddings below length
      '{iff_pkg::KIND_OCT,  32'h4000_0000,  6'd0,  6'd0},
      '{iff_pkg::KIND_BIN,  32'h0000_002A,  6'd40, 6'd20},
      '{KIND_UNUSED_6,      32'hFFFF_FFFF,  6'd63, 6'd63},
      '{KIND_UNUSED_7,      32'd0,          6'd0,  6'd0}
    };
    dir_text = '{
      "0", "-2147483648", "-1", "2147483647", "4294967295", "2147483648",
      "37777777777", "0", "11111111111111111111111111111111", "1",
      "deadbeef", "  ffffffff", "A", "   -05", "00042",
      "", "", "", "", "", "", "", "", "", "", ""
    };

    rst_ni       = 1'b0;
    start        = 1'b0;
    kind_i       = iff_pkg::KIND_SDEC;
    value_i      = 32'd0;
    width_i      = 6'd0;
    min_digits_i = 6'd0;
    golden_text  = "";
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_word(dir_words[r].kind, dir_words[r].value, dir_words[r].width,
                dir_words[r].min_digits, dir_text[r]);
    end
    wait_fields_done();

    // Random words. Values lean toward the corners (small numbers, powers of
    // two, the sign boundary, decimal digit-count boundaries); paddings are
    // mostly short so that the run stays fast, with the full range mixed in.
    taken  = 0;
    paused = 1'b0;
    while (taken < NUM_RANDOM) begin
      if ($urandom_range(0, 19) == 0) begin
        kind = ($urandom_range(0, 1) == 0) ? KIND_UNUSED_6 : KIND_UNUSED_7;
      end else begin
        kind = 3'($urandom_range(0, 5));
        taken++;
      end
      case ($urandom_range(0, 7))
        0:       value = $urandom();
        1:       value = $urandom_range(0, 20);
        2:       value = 32'd1 << $urandom_range(0, 31);
        3:       value = 32'd0 - $urandom_range(1, 1000);
        4:       value = 32'h8000_0000 ^ $urandom_range(0, 3);
        5:       value = $urandom_range(999999990, 1000000010);
        6:       value = 32'hFFFF_FFFF - $urandom_range(0, 5);
        default: value = $urandom() & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
      endcase
      case ($urandom_range(0, 9))
        7, 8:    width = 6'($urandom_range(0, 63));
        9:       width = 6'd63;
        default: width = 6'($urandom_range(0, 12));
      endcase
      case ($urandom_range(0, 9))
        7, 8:    min_digits = 6'($urandom_range(0, 63));
        9:       min_digits = 6'd0;
        default: min_digits = 6'($urandom_range(0, 12));
      endcase
      send_word(kind, value, width, min_digits, "");
      // Once, mid-run, let the block drain completely before going on.
      if (!paused && taken == NUM_RANDOM / 2) begin
        paused = 1'b1;
        wait_fields_done();
      end
    end

    wait_fields_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
